@@ design/wsf_pkg.sv @@
`timescale 1ns / 1ps

package wsf_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SPEED_W  = 32;
  localparam int unsigned GEAR_W   = 8;
  localparam int unsigned MOD_W    = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // datapath widths: four 17x16 products summed, then >>15, then times gear
  localparam int unsigned ACC_W  = 35;
  localparam int unsigned FILT_W = ACC_W - 1 - 15;
  localparam int unsigned PER_W  = FILT_W + GEAR_W;
  localparam int unsigned DIV_CNT_W = 5;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MODULUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ZERO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ONE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TWO      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_THREE    = 3'd6;

  // reset values
  localparam logic [GEAR_W-1:0] GEAR_RST    = 8'd8;
  localparam logic [MOD_W-1:0]  MOD_RST     = 16'hFFFF;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd100;
  localparam logic [COEF_W-1:0] COEF_RST    = 16'd8192;

  localparam logic FUNC_MEASURE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

@@ design/wheel_speed_from_period_fir.sv @@
`timescale 1ns / 1ps

// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_func, in_period_sample, in_now
// out      output     out_valid / out_ready out_wheel_speed, out_stationary
// cfg      input      cfg_we (no wait)      cfg_index, cfg_wdata
//
// a poll goes from accept through ST_DONE to the output register; a new period goes
// through ST_MAC, where one shared multiplier walks the ring oldest to newest, then ST_SCALE,
// which scales by the gear ratio, and ST_DIV, a restoring divider that ends at once for a zero period.
// in_ready is high only while idle; a held result in the output register
// stalls the next result, not the accept. synchronous reset clears the ring,
// the speed and loads the register reset values.

module wheel_speed_from_period_fir #(
  parameter int unsigned TAPS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_func,
  input  logic [wsf_pkg::SAMPLE_W-1:0]       in_period_sample,
  input  logic [wsf_pkg::TIME_W-1:0]         in_now,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wsf_pkg::SPEED_W-1:0]        out_wheel_speed,
  output logic                               out_stationary,
  input  logic                               cfg_we,
  input  logic [wsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsf_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int unsigned SLOT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TAPS - 1);
  localparam logic [1:0] STEP_LAST = 2'(TAPS - 1);
  localparam logic [1:0] COEF_OFS  = 2'(4 - TAPS);

  wsf_pkg::state_t state_r, state_nxt;

  logic [wsf_pkg::GEAR_W-1:0]  gear_r;
  logic [wsf_pkg::MOD_W-1:0]   modulus_r;
  logic [wsf_pkg::TIME_W-1:0]  timeout_r;
  logic signed [wsf_pkg::COEF_W-1:0] coef_r [4];

  logic [wsf_pkg::SAMPLE_W-1:0] ring_r [TAPS];
  logic                          ring_we;

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] elem_r, elem_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [wsf_pkg::TIME_W-1:0]  last_r, last_nxt;
  logic [wsf_pkg::SPEED_W-1:0] speed_r, speed_nxt;

  logic signed [wsf_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [wsf_pkg::PER_W-1:0]        div_r, div_nxt;
  logic [wsf_pkg::PER_W-1:0]        rem_r, rem_nxt;
  logic [wsf_pkg::SPEED_W-1:0]      quo_r, quo_nxt;
  logic [wsf_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [wsf_pkg::SPEED_W-1:0]   out_speed_r, out_speed_nxt;
  logic                          out_stat_r, out_stat_nxt;

  logic [1:0]                          coef_idx;
  logic signed [wsf_pkg::COEF_W:0]     samp_s;
  logic signed [2*wsf_pkg::COEF_W:0]   prod;
  logic [wsf_pkg::FILT_W-1:0]          filt;
  logic [wsf_pkg::PER_W:0]             rem_sh;
  logic [wsf_pkg::PER_W:0]             rem_diff;
  logic                                rem_ge;
  logic [SLOT_W-1:0]                   slot_inc;
  logic [SLOT_W-1:0]                   elem_inc;

  assign in_ready        = (state_r == wsf_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_wheel_speed = out_speed_r;
  assign out_stationary  = out_stat_r;

  assign slot_inc = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
  assign elem_inc = (elem_r == SLOT_LAST) ? '0 : elem_r + 1'b1;

  // shared multiplier: newest sample pairs with coef_three
  assign coef_idx = step_r + COEF_OFS;
  assign samp_s   = $signed({1'b0, ring_r[elem_r]});
  assign prod     = samp_s * coef_r[coef_idx];

  // negative sum clamps to zero, else truncate by 15
  assign filt = acc_r[wsf_pkg::ACC_W-1] ? '0 : acc_r[wsf_pkg::ACC_W-2:15];

  assign rem_sh   = {rem_r, quo_r[wsf_pkg::SPEED_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, div_r};
  assign rem_diff = rem_sh - {1'b0, div_r};

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    elem_nxt      = elem_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    speed_nxt     = speed_r;
    acc_nxt       = acc_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    ring_we       = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_speed_nxt = out_speed_r;
    out_stat_nxt  = out_stat_r;
    case (state_r)
      wsf_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_func == wsf_pkg::FUNC_MEASURE) begin
            ring_we   = 1'b1;
            slot_nxt  = slot_inc;
            elem_nxt  = slot_inc;
            step_nxt  = '0;
            acc_nxt   = '0;
            last_nxt  = in_now;
            state_nxt = wsf_pkg::ST_MAC;
          end else begin
            if ((in_now - last_r) > timeout_r) begin
              speed_nxt = '0;
            end
            state_nxt = wsf_pkg::ST_DONE;
          end
        end
      end
      wsf_pkg::ST_MAC: begin
        acc_nxt  = acc_r + wsf_pkg::ACC_W'(prod);
        elem_nxt = elem_inc;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = wsf_pkg::ST_SCALE;
        end
      end
      wsf_pkg::ST_SCALE: begin
        div_nxt   = wsf_pkg::PER_W'(filt) * wsf_pkg::PER_W'(gear_r);
        rem_nxt   = '0;
        quo_nxt   = {modulus_r, 16'h0000};
        cnt_nxt   = '0;
        state_nxt = wsf_pkg::ST_DIV;
      end
      wsf_pkg::ST_DIV: begin
        if (div_r == '0) begin
          speed_nxt = '0;
          state_nxt = wsf_pkg::ST_DONE;
        end else begin
          rem_nxt = rem_ge ? rem_diff[wsf_pkg::PER_W-1:0] : rem_sh[wsf_pkg::PER_W-1:0];
          quo_nxt = {quo_r[wsf_pkg::SPEED_W-2:0], rem_ge};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == '1) begin
            speed_nxt = {quo_r[wsf_pkg::SPEED_W-2:0], rem_ge};
            state_nxt = wsf_pkg::ST_DONE;
          end
        end
      end
      wsf_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = speed_r;
          out_stat_nxt  = (speed_r == '0);
          state_nxt     = wsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wsf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsf_pkg::ST_IDLE;
      slot_r      <= '0;
      elem_r      <= '0;
      step_r      <= '0;
      last_r      <= '0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
      gear_r      <= wsf_pkg::GEAR_RST;
      modulus_r   <= wsf_pkg::MOD_RST;
      timeout_r   <= wsf_pkg::TIMEOUT_RST;
      for (int i = 0; i < 4; i++) begin
        coef_r[i] <= wsf_pkg::COEF_RST;
      end
      for (int i = 0; i < TAPS; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      elem_r      <= elem_nxt;
      step_r      <= step_nxt;
      last_r      <= last_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
      if (ring_we) begin
        ring_r[slot_r] <= in_period_sample;
      end
      if (cfg_we) begin
        case (cfg_index)
          wsf_pkg::CFG_GEAR_RATIO:    gear_r    <= cfg_wdata[wsf_pkg::GEAR_W-1:0];
          wsf_pkg::CFG_TIMER_MODULUS: modulus_r <= cfg_wdata[wsf_pkg::MOD_W-1:0];
          wsf_pkg::CFG_STALL_TIMEOUT: timeout_r <= cfg_wdata[wsf_pkg::TIME_W-1:0];
          wsf_pkg::CFG_COEF_ZERO:     coef_r[0] <= cfg_wdata[wsf_pkg::COEF_W-1:0];
          wsf_pkg::CFG_COEF_ONE:      coef_r[1] <= cfg_wdata[wsf_pkg::COEF_W-1:0];
          wsf_pkg::CFG_COEF_TWO:      coef_r[2] <= cfg_wdata[wsf_pkg::COEF_W-1:0];
          wsf_pkg::CFG_COEF_THREE:    coef_r[3] <= cfg_wdata[wsf_pkg::COEF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath and output payload
  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    out_speed_r <= out_speed_nxt;
    out_stat_r  <= out_stat_nxt;
  end

endmodule

@@ bench/wheel_speed_from_period_fir_test.sv @@
`timescale 1ns / 1ps

module wheel_speed_from_period_fir_test;

  localparam int TAP_COUNT = 4;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = TAP_COUNT + 40;
  localparam logic FUNC_POLL = ~wsf_pkg::FUNC_MEASURE;
  localparam logic FUNC_MEAS = wsf_pkg::FUNC_MEASURE;
  localparam logic TYPED = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic [wsf_pkg::SPEED_W-1:0] speed;
    logic                        stationary;
  } speed_result_t;

  typedef struct packed {
    logic                         func;
    logic [wsf_pkg::SAMPLE_W-1:0] sample;
    logic [wsf_pkg::TIME_W-1:0]   now;
    logic                         typed;
    logic [wsf_pkg::SPEED_W-1:0]  speed;
    logic                         stationary;
  } stim_row_t;

  // typed results: reset state, zero periods, timeouts, rings full of one value
  localparam stim_row_t DIRECTED_ROWS [21] = '{
    {FUNC_POLL, 16'h0000, 32'h0000_0000, TYPED,     32'h0000_0000, 1'b1},
    {FUNC_POLL, 16'hFFFF, 32'hFFFF_FFFF, TYPED,     32'h0000_0000, 1'b1},
    {FUNC_MEAS, 16'h0000, 32'd5,         TYPED,     32'h0000_0000, 1'b1},
    {FUNC_MEAS, 16'hFFFF, 32'd10,        PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_MEAS, 16'hFFFF, 32'd20,        PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_MEAS, 16'hFFFF, 32'd30,        PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_MEAS, 16'hFFFF, 32'd40,        TYPED,     32'h0000_2000, 1'b0},
    {FUNC_POLL, 16'h0000, 32'd140,       TYPED,     32'h0000_2000, 1'b0},
    {FUNC_POLL, 16'h0000, 32'd141,       TYPED,     32'h0000_0000, 1'b1},
    {FUNC_MEAS, 16'h0001, 32'd150,       PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_MEAS, 16'h0001, 32'd160,       PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_MEAS, 16'h0001, 32'd170,       PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_MEAS, 16'h0001, 32'd180,       TYPED,     32'h1FFF_E000, 1'b0},
    {FUNC_POLL, 16'h0000, 32'd5,         TYPED,     32'h0000_0000, 1'b1},
    {FUNC_MEAS, 16'h5555, 32'hAAAA_AAAA, PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_MEAS, 16'hAAAA, 32'h5555_5555, PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_POLL, 16'h0000, 32'h5555_55B9, PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_MEAS, 16'h8000, 32'hFFFF_FFFF, PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_POLL, 16'h0000, 32'h0000_0063, PREDICTED, 32'h0000_0000, 1'b0},
    {FUNC_POLL, 16'h0000, 32'h0000_0064, TYPED,     32'h0000_0000, 1'b1},
    {FUNC_MEAS, 16'h0000, 32'h0000_0070, PREDICTED, 32'h0000_0000, 1'b0}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_func = 1'b0;
  logic [wsf_pkg::SAMPLE_W-1:0]  in_period_sample = '0;
  logic [wsf_pkg::TIME_W-1:0]    in_now = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [wsf_pkg::SPEED_W-1:0]   out_wheel_speed;
  logic                          out_stationary;
  logic                          cfg_we = 1'b0;
  logic [wsf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wsf_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // speed model state and register copies
  logic [wsf_pkg::GEAR_W-1:0]        gear_ratio;
  logic [wsf_pkg::MOD_W-1:0]         timer_modulus;
  logic [wsf_pkg::TIME_W-1:0]        stall_timeout;
  logic signed [wsf_pkg::COEF_W-1:0] coef_w [4];
  logic [wsf_pkg::SAMPLE_W-1:0]      period_ring [TAP_COUNT];
  int                                write_slot;
  logic [wsf_pkg::TIME_W-1:0]        last_sample_time;
  logic [wsf_pkg::SPEED_W-1:0]       speed_value;

  speed_result_t expected_speeds [$];
  logic [wsf_pkg::TIME_W-1:0] now_cursor = '0;
  logic idle_on = 1'b1;
  int ready_hold = 0;
  int mismatches = 0;
  int stalled_cycles = 0;

  wheel_speed_from_period_fir #(
    .TAPS(TAP_COUNT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_period_sample(in_period_sample),
    .in_now(in_now),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_wheel_speed(out_wheel_speed),
    .out_stationary(out_stationary),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic advance_speed_model(input logic func,
                                     input logic [wsf_pkg::SAMPLE_W-1:0] sample,
                                     input logic [wsf_pkg::TIME_W-1:0] now,
                                     output speed_result_t res);
    logic [wsf_pkg::TIME_W-1:0] elapsed;
    longint acc;
    logic [63:0] filt;
    logic [63:0] scaled;
    logic [63:0] quot;
    elapsed = now - last_sample_time;
    if (func == FUNC_POLL) begin
      if (elapsed > stall_timeout) speed_value = '0;
    end else begin
      period_ring[write_slot] = sample;
      write_slot = (write_slot + 1) % TAP_COUNT;
      last_sample_time = now;
      // oldest to newest; the newest always takes the last weight
      acc = 0;
      for (int s = 0; s < TAP_COUNT; s++) begin
        acc += longint'(period_ring[(write_slot + s) % TAP_COUNT]) *
               longint'(coef_w[s + 4 - TAP_COUNT]);
      end
      filt = (acc < 0) ? 64'd0 : 64'(acc >>> 15);
      scaled = filt * {56'd0, gear_ratio};
      if (scaled == 0) begin
        speed_value = '0;
      end else begin
        quot = {32'd0, timer_modulus, 16'd0} / scaled;
        speed_value = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
      end
    end
    res.speed = speed_value;
    res.stationary = (speed_value == 0);
  endtask

  task automatic send_request(input logic func, input logic [wsf_pkg::SAMPLE_W-1:0] sample,
                              input logic [wsf_pkg::TIME_W-1:0] now, input logic typed,
                              input speed_result_t typed_res);
    speed_result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_period_sample <= sample;
    in_now <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_speed_model(func, sample, now, predicted);
    expected_speeds.push_back(typed ? typed_res : predicted);
  endtask

  task automatic write_reg(input logic [wsf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wsf_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      wsf_pkg::CFG_GEAR_RATIO:    gear_ratio = value[wsf_pkg::GEAR_W-1:0];
      wsf_pkg::CFG_TIMER_MODULUS: timer_modulus = value[wsf_pkg::MOD_W-1:0];
      wsf_pkg::CFG_STALL_TIMEOUT: stall_timeout = value[wsf_pkg::TIME_W-1:0];
      wsf_pkg::CFG_COEF_ZERO:     coef_w[0] = value[wsf_pkg::COEF_W-1:0];
      wsf_pkg::CFG_COEF_ONE:      coef_w[1] = value[wsf_pkg::COEF_W-1:0];
      wsf_pkg::CFG_COEF_TWO:      coef_w[2] = value[wsf_pkg::COEF_W-1:0];
      wsf_pkg::CFG_COEF_THREE:    coef_w[3] = value[wsf_pkg::COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_for_results();
    while (expected_speeds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic make_item(output logic func, output logic [wsf_pkg::SAMPLE_W-1:0] sample);
    int pick;
    func = ($urandom_range(0, 9) < 6) ? FUNC_MEAS : FUNC_POLL;
    pick = $urandom_range(0, 9);
    if (pick < 5) sample = wsf_pkg::SAMPLE_W'($urandom());
    else if (pick < 8) sample = wsf_pkg::SAMPLE_W'($urandom_range(1, 300));
    else if (pick == 8) sample = '0;
    else sample = '1;
    pick = $urandom_range(0, 9);
    if (pick < 7) now_cursor = now_cursor + $urandom_range(0, 60);
    // land just around the timeout boundary
    else if (pick < 9) now_cursor = last_sample_time + stall_timeout + $urandom_range(0, 2) - 1;
    else now_cursor = $urandom();
  endtask

  function automatic logic [wsf_pkg::COEF_W-1:0] pick_coef();
    if ($urandom_range(0, 3) == 0) return wsf_pkg::COEF_W'($urandom());
    return wsf_pkg::COEF_W'($urandom_range(0, 32767));
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    speed_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_speeds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no request pending: speed %h stationary %b",
                   out_wheel_speed, out_stationary);
      end else begin
        want = expected_speeds.pop_front();
        if (out_wheel_speed !== want.speed || out_stationary !== want.stationary) begin
          mismatches++;
          if (mismatches <= 10)
            $display("speed mismatch: expected %h stationary %b, got %h stationary %b",
                     want.speed, want.stationary, out_wheel_speed, out_stationary);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic func;
    logic [wsf_pkg::SAMPLE_W-1:0] sample;
    logic [wsf_pkg::COEF_W-1:0] coef_vals [4];
    logic [wsf_pkg::GEAR_W-1:0] gear_val;
    logic [wsf_pkg::MOD_W-1:0] mod_val;
    logic [wsf_pkg::TIME_W-1:0] timeout_val;
    stim_row_t row;
    int pick;

    gear_ratio = wsf_pkg::GEAR_RST;
    timer_modulus = wsf_pkg::MOD_RST;
    stall_timeout = wsf_pkg::TIMEOUT_RST;
    for (int k = 0; k < 4; k++) coef_w[k] = wsf_pkg::COEF_RST;
    for (int k = 0; k < TAP_COUNT; k++) period_ring[k] = '0;
    write_slot = 0;
    last_sample_time = '0;
    speed_value = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      send_request(row.func, row.sample, row.now, row.typed, {row.speed, row.stationary});
    end
    in_valid <= 1'b0;
    now_cursor = last_sample_time;

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      for (int k = 0; k < 4; k++) coef_vals[k] = pick_coef();
      gear_val = wsf_pkg::GEAR_W'($urandom_range(1, 255));
      mod_val = wsf_pkg::MOD_W'($urandom_range(1, 65535));
      pick = $urandom_range(0, 3);
      timeout_val = (pick == 0) ? 32'd0 : (pick == 1) ? 32'($urandom_range(1, 300)) :
                    (pick == 2) ? 32'($urandom()) : 32'hFFFF_FFFF;
      case (phase)
        0: begin
          gear_val = 8'd255;
          mod_val = 16'hFFFF;
          timeout_val = 32'd0;
          for (int k = 0; k < 4; k++) coef_vals[k] = 16'h7FFF;
        end
        1: begin
          // every sum goes negative or zero
          gear_val = 8'd1;
          mod_val = 16'd1;
          timeout_val = 32'hFFFF_FFFF;
          for (int k = 0; k < 4; k++) coef_vals[k] = 16'h8000;
        end
        2: gear_val = 8'd0;
        3: begin
          gear_val = 8'd1;
          mod_val = 16'hFFFF;
          coef_vals[0] = 16'h7FFF;
          coef_vals[1] = 16'h8000;
          coef_vals[2] = 16'h4000;
          coef_vals[3] = 16'h2000;
        end
        default: ;
      endcase
      write_reg(wsf_pkg::CFG_GEAR_RATIO, {24'd0, gear_val});
      write_reg(wsf_pkg::CFG_TIMER_MODULUS, {16'd0, mod_val});
      write_reg(wsf_pkg::CFG_STALL_TIMEOUT, timeout_val);
      for (int k = 0; k < 4; k++)
        write_reg(wsf_pkg::CFG_IDX_W'(wsf_pkg::CFG_COEF_ZERO + k),
                  {{16{coef_vals[k][wsf_pkg::COEF_W-1]}}, coef_vals[k]});
      cfg_we <= 1'b0;
      idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        make_item(func, sample);
        send_request(func, sample, now_cursor, PREDICTED, '0);
      end
      in_valid <= 1'b0;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_speeds.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
